>>> sv/kmeans_clustering_2d_macros.svh
// assertion macros shared by the clustering block
`ifndef KMEANS_CLUSTERING_2D_MACROS_SVH
`define KMEANS_CLUSTERING_2D_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every edge
`define KMC_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kmc assertion failed");

// consequent holds in the same cycle
`define KMC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmc assertion failed");

// consequent holds in the next cycle
`define KMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmc assertion failed");

`else

`define KMC_ASSERT(lbl, clk, rst, cond)
`define KMC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define KMC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> sv/kmc_pkg.sv
package kmc_pkg;

  // sizes
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 32;
  localparam int COORD_W      = 32;
  localparam int PIDX_W       = $clog2(MAX_POINTS);
  localparam int PCNT_W       = PIDX_W + 1;
  localparam int CIDX_W       = $clog2(MAX_CLUSTERS);
  localparam int CCNT_W       = CIDX_W + 1;
  localparam int SUM_W        = COORD_W + PIDX_W;
  localparam int DIST_W       = 2 * COORD_W + 1;
  localparam int INERTIA_W    = 63;
  localparam int ITER_W       = 11;
  localparam int MAX_ITER     = 1024;
  localparam int TOL_W        = 31;
  localparam int DIV_CNT_W    = $clog2(SUM_W);

  // pipeline flush length after the last issue of a phase
  localparam int DRAIN_CYCLES = 7;
  localparam int DRAIN_W      = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 2'd2;

  // commands
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_LOAD_POINT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_CENTRE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN         = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic [PCNT_W-1:0]       cnt;
  } sum_entry_t;

  // travels alongside a distance through the distance pipeline
  typedef struct packed {
    logic              first;
    logic              last;
    logic [CIDX_W-1:0] cidx;
    logic [PIDX_W-1:0] pidx;
    coord_t            px;
    coord_t            py;
  } dist_tag_t;

endpackage

>>> sv/kmc_ram.sv
module kmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port, read returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/kmc_dist.sv
module kmc_dist (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  kmc_pkg::coord_t    ax,
  input  kmc_pkg::coord_t    ay,
  input  kmc_pkg::coord_t    bx,
  input  kmc_pkg::coord_t    by,
  input  kmc_pkg::dist_tag_t in_tag,
  output logic               out_valid,
  output kmc_pkg::dist_t     dist_sq,
  output kmc_pkg::dist_tag_t out_tag
);
  import kmc_pkg::*;

  logic [COORD_W:0]     diff_x, diff_y, neg_x, neg_y;
  logic [COORD_W-1:0]   mag_x, mag_y;
  logic                 v1, v2, v3;
  logic [COORD_W-1:0]   dx1, dy1;
  logic [2*COORD_W-1:0] sqx2, sqy2;
  dist_tag_t            t1, t2, t3;
  dist_t                dist3;

  // absolute coordinate differences, always fit the coordinate width
  always_comb begin
    diff_x = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
    diff_y = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    mag_x  = diff_x[COORD_W] ? neg_x[COORD_W-1:0] : diff_x[COORD_W-1:0];
    mag_y  = diff_y[COORD_W] ? neg_y[COORD_W-1:0] : diff_y[COORD_W-1:0];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // difference, square, sum stages
  always_ff @(posedge clk) begin
    dx1   <= mag_x;
    dy1   <= mag_y;
    t1    <= in_tag;
    sqx2  <= (2*COORD_W)'(dx1) * (2*COORD_W)'(dx1);
    sqy2  <= (2*COORD_W)'(dy1) * (2*COORD_W)'(dy1);
    t2    <= t1;
    dist3 <= {1'b0, sqx2} + {1'b0, sqy2};
    t3    <= t2;
  end

  assign out_valid = v3;
  assign dist_sq   = dist3;
  assign out_tag   = t3;

endmodule

>>> sv/kmc_div.sv
module kmc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [kmc_pkg::SUM_W-1:0] dividend,
  input  logic [kmc_pkg::PCNT_W-1:0] divisor,
  output logic                      done,
  output logic [kmc_pkg::SUM_W-1:0] quotient
);
  import kmc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W-1:0]     q;
  logic [PCNT_W-1:0]    rem, dvs;
  logic [PCNT_W:0]      shifted, trial;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem, q[SUM_W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          rem <= trial[PCNT_W-1:0];
          q   <= {q[SUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[PCNT_W-1:0];
          q   <= {q[SUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

>>> sv/kmeans_clustering_2d.sv
// Two-dimensional k-means (Lloyd) engine on signed Q16.16 points. Load points
// (command 0, up to 1024, extra ones dropped) and initial centres (command 1,
// up to 32, in order), then issue command 2 to run; the run emits one
// transaction per centre 0..k-1 and continues from the centres of any earlier
// run. Each pass, for N points and k centres, clears the sums, then assigns
// the points (one point-centre distance per cycle through the distance
// pipeline, N*k pairs, then a drain), updates each centre through the iterative
// dividers (no division for an empty cluster) and sums the inertia over the N
// points; each result then goes out in turn, held by output stall. Points,
// labels, centres and per-cluster sums live in single-port-read RAMs; the run
// passes and the emission hold off new input transactions until the last
// result is taken.
`include "kmeans_clustering_2d_macros.svh"

module kmeans_clustering_2d (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kmc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kmc_pkg::CMD_W-1:0]       command,
  input  logic signed [kmc_pkg::COORD_W-1:0] x_coord,
  input  logic signed [kmc_pkg::COORD_W-1:0] y_coord,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kmc_pkg::CIDX_W-1:0]      center_index,
  output logic signed [kmc_pkg::COORD_W-1:0] center_x,
  output logic signed [kmc_pkg::COORD_W-1:0] center_y,
  output logic [kmc_pkg::PCNT_W-1:0]      member_count,
  output logic [kmc_pkg::ITER_W-1:0]      passes_run,
  output logic                            converged,
  output logic [kmc_pkg::INERTIA_W-1:0]   inertia,
  output logic                            last_center
);
  import kmc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_ASSIGN, S_ASSIGN_DRAIN, S_UPD_RD, S_UPD_LD, S_UPD_DIV,
    S_UPD_MOVE, S_INERT, S_INERT_DRAIN, S_EMIT_RD, S_EMIT_LD, S_EMIT_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CCNT_W-1:0] num_clusters;
  logic [TOL_W-1:0]  move_tolerance;
  logic [ITER_W-1:0] max_iterations;

  // run control
  logic [PCNT_W-1:0]  point_total;
  logic [CCNT_W-1:0]  centres_loaded;
  logic [CIDX_W-1:0]  k_last, k_last_run, ci;
  logic [ITER_W-1:0]  iter_lim, lim_run, iter, iter_inc;
  logic [2*TOL_W-1:0] tol2, tol_sq;
  logic [PIDX_W-1:0]  pi, last_pt;
  logic [DRAIN_W-1:0] drain;
  logic               conv;
  logic [INERTIA_W-1:0] inertia_acc;

  // assignment issue stage
  logic              a_valid, a_first, a_last;
  logic [CIDX_W-1:0] a_cidx;
  logic [PIDX_W-1:0] a_pidx;

  // inertia issue stages
  logic              r0_valid, r1_valid;
  logic [PIDX_W-1:0] r0_pidx;

  // centre update
  sum_entry_t       upd_sum;
  coord_t           old_x, old_y, new_x, new_y;
  logic             mv_valid;
  logic [SUM_W-1:0] sx_mag, sy_mag, qn_x, qn_y, div_q_x, div_q_y;
  logic             div_start, div_done_x, div_done_y;

  // memories
  logic              pt_we;
  point_t            pt_wdata, pt_rd;
  logic [PIDX_W-1:0] pt_raddr;
  logic              lbl_we;
  logic [CIDX_W-1:0] final_label, label_rd;
  logic              ctr_we;
  logic [CIDX_W-1:0] ctr_waddr, ctr_raddr;
  point_t            ctr_wdata, ctr_rd;
  logic              sum_we;
  logic [CIDX_W-1:0] sum_waddr, sum_raddr;
  sum_entry_t        sum_wdata, sum_rd;

  // distance pipeline
  logic      d_in_valid, d_valid;
  coord_t    d_ax, d_ay, d_bx, d_by;
  dist_tag_t d_in_tag, d_tag;
  dist_t     d_dist;

  // nearest centre tracking and sum accumulation
  dist_t             best_dist;
  logic [CIDX_W-1:0] best_idx;
  logic              d_better, assign_ph, inert_ph;
  logic              acc_valid, fwd_valid;
  logic [CIDX_W-1:0] acc_label, fwd_addr;
  coord_t            acc_px, acc_py;
  sum_entry_t        acc_old, acc_new, fwd_data;

  // inertia accumulation
  logic [INERTIA_W:0]   inert_sum;
  logic [INERTIA_W-1:0] inert_next;
  logic                 inert_sat;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign assign_ph = (state == S_ASSIGN) || (state == S_ASSIGN_DRAIN);
  assign inert_ph  = (state == S_INERT) || (state == S_INERT_DRAIN);
  assign last_pt   = PIDX_W'(point_total - 1'b1);
  assign iter_inc  = iter + 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters   <= CCNT_W'(3);
      move_tolerance <= TOL_W'(7);
      max_iterations <= ITER_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_CLUSTERS:   num_clusters   <= cfg_data[CCNT_W-1:0];
        REG_MOVE_TOLERANCE: move_tolerance <= cfg_data[TOL_W-1:0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // run parameters with out-of-range values clamped
  always_comb begin
    if (num_clusters == '0) begin
      k_last_run = '0;
    end else if (num_clusters > CCNT_W'(MAX_CLUSTERS)) begin
      k_last_run = CIDX_W'(MAX_CLUSTERS - 1);
    end else begin
      k_last_run = CIDX_W'(num_clusters - 1'b1);
    end
    if (max_iterations == '0) begin
      lim_run = ITER_W'(1);
    end else if (max_iterations > ITER_W'(MAX_ITER)) begin
      lim_run = ITER_W'(MAX_ITER);
    end else begin
      lim_run = max_iterations;
    end
    tol_sq = (2*TOL_W)'(move_tolerance) * (2*TOL_W)'(move_tolerance);
  end

  // point store
  assign pt_we    = in_valid && in_ready && (command == CMD_LOAD_POINT) &&
                    (point_total < PCNT_W'(MAX_POINTS));
  assign pt_wdata = {x_coord, y_coord};
  assign pt_raddr = inert_ph ? r0_pidx : pi;

  kmc_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk(clk), .we(pt_we), .waddr(point_total[PIDX_W-1:0]), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rd)
  );

  // label store
  kmc_ram #(.WIDTH(CIDX_W), .DEPTH(MAX_POINTS)) u_label_ram (
    .clk(clk), .we(lbl_we), .waddr(d_tag.pidx), .wdata(final_label),
    .raddr(pi), .rdata(label_rd)
  );

  // centre store: loads while idle, updates in the update phase of each pass
  always_comb begin
    if (state == S_IDLE) begin
      ctr_we    = in_valid && (command == CMD_LOAD_CENTRE) &&
                  (centres_loaded < CCNT_W'(MAX_CLUSTERS));
      ctr_waddr = centres_loaded[CIDX_W-1:0];
      ctr_wdata = {x_coord, y_coord};
    end else begin
      ctr_we    = (state == S_UPD_MOVE) && d_valid;
      ctr_waddr = ci;
      ctr_wdata = {new_x, new_y};
    end
    ctr_raddr = (inert_ph && r0_valid) ? label_rd : ci;
  end

  kmc_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_CLUSTERS)) u_centre_ram (
    .clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
    .raddr(ctr_raddr), .rdata(ctr_rd)
  );

  // per-cluster sums: cleared by sweep, then read-modify-write per point
  always_comb begin
    acc_old = (fwd_valid && (fwd_addr == acc_label)) ? fwd_data : sum_rd;
    acc_new.sx  = acc_old.sx + SUM_W'(acc_px);
    acc_new.sy  = acc_old.sy + SUM_W'(acc_py);
    acc_new.cnt = acc_old.cnt + 1'b1;
    sum_we    = acc_valid || (state == S_CLEAR);
    sum_waddr = acc_valid ? acc_label : ci;
    sum_wdata = acc_valid ? acc_new : '0;
    sum_raddr = lbl_we ? final_label : ci;
  end

  kmc_ram #(.WIDTH($bits(sum_entry_t)), .DEPTH(MAX_CLUSTERS)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rd)
  );

  // shared distance pipeline
  always_comb begin
    d_in_valid = a_valid || r1_valid || mv_valid;
    d_ax = mv_valid ? new_x : pt_rd.x;
    d_ay = mv_valid ? new_y : pt_rd.y;
    d_bx = mv_valid ? old_x : ctr_rd.x;
    d_by = mv_valid ? old_y : ctr_rd.y;
    d_in_tag.first = a_first;
    d_in_tag.last  = a_last;
    d_in_tag.cidx  = a_cidx;
    d_in_tag.pidx  = a_pidx;
    d_in_tag.px    = pt_rd.x;
    d_in_tag.py    = pt_rd.y;
  end

  kmc_dist u_dist (
    .clk(clk), .rst(rst), .in_valid(d_in_valid),
    .ax(d_ax), .ay(d_ay), .bx(d_bx), .by(d_by), .in_tag(d_in_tag),
    .out_valid(d_valid), .dist_sq(d_dist), .out_tag(d_tag)
  );

  // nearest centre, ties keep the lower index
  always_comb begin
    d_better    = d_tag.first || (d_dist < best_dist);
    final_label = d_better ? d_tag.cidx : best_idx;
    lbl_we      = d_valid && assign_ph && d_tag.last;
  end

  always_ff @(posedge clk) begin
    if (d_valid && assign_ph && d_better) begin
      best_dist <= d_dist;
      best_idx  <= d_tag.cidx;
    end
    acc_label <= final_label;
    acc_px    <= d_tag.px;
    acc_py    <= d_tag.py;
    fwd_addr  <= acc_label;
    fwd_data  <= acc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      acc_valid <= lbl_we;
      fwd_valid <= acc_valid;
    end
  end

  // mean by division of magnitudes, truncating toward zero
  always_comb begin
    sx_mag    = sum_rd.sx[SUM_W-1] ? SUM_W'(-sum_rd.sx) : SUM_W'(sum_rd.sx);
    sy_mag    = sum_rd.sy[SUM_W-1] ? SUM_W'(-sum_rd.sy) : SUM_W'(sum_rd.sy);
    div_start = (state == S_UPD_LD) && (sum_rd.cnt != '0);
    qn_x      = -div_q_x;
    qn_y      = -div_q_y;
  end

  kmc_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sx_mag),
    .divisor(sum_rd.cnt), .done(div_done_x), .quotient(div_q_x)
  );

  kmc_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sy_mag),
    .divisor(sum_rd.cnt), .done(div_done_y), .quotient(div_q_y)
  );

  // saturating inertia sum
  always_comb begin
    inert_sum  = (INERTIA_W+1)'(inertia_acc) + (INERTIA_W+1)'(d_dist[INERTIA_W-1:0]);
    inert_sat  = d_dist[DIST_W-1] || d_dist[DIST_W-2] || inert_sum[INERTIA_W];
    inert_next = inert_sat ? '1 : inert_sum[INERTIA_W-1:0];
  end

  // pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      point_total    <= '0;
      centres_loaded <= '0;
      out_valid      <= 1'b0;
      a_valid        <= 1'b0;
      r0_valid       <= 1'b0;
      r1_valid       <= 1'b0;
      mv_valid       <= 1'b0;
      iter           <= '0;
      ci             <= '0;
      pi             <= '0;
      drain          <= '0;
      conv           <= 1'b0;
    end else begin
      a_valid  <= 1'b0;
      r0_valid <= 1'b0;
      r1_valid <= r0_valid;
      mv_valid <= 1'b0;
      if (d_valid && inert_ph) begin
        inertia_acc <= inert_next;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (command)
              CMD_LOAD_POINT: begin
                if (point_total < PCNT_W'(MAX_POINTS)) begin
                  point_total <= point_total + 1'b1;
                end
              end
              CMD_LOAD_CENTRE: begin
                if (centres_loaded < CCNT_W'(MAX_CLUSTERS)) begin
                  centres_loaded <= centres_loaded + 1'b1;
                end
              end
              CMD_RUN: begin
                k_last      <= k_last_run;
                iter_lim    <= lim_run;
                tol2        <= tol_sq;
                iter        <= '0;
                conv        <= 1'b1;
                inertia_acc <= '0;
                ci          <= '0;
                state       <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        // zero all cluster sums
        S_CLEAR: begin
          ci <= ci + 1'b1;
          if (ci == CIDX_W'(MAX_CLUSTERS - 1)) begin
            ci    <= '0;
            pi    <= '0;
            state <= (point_total == '0) ? S_UPD_RD : S_ASSIGN;
          end
        end
        // one point-centre pair per cycle
        S_ASSIGN: begin
          a_valid <= 1'b1;
          a_first <= (ci == '0);
          a_last  <= (ci == k_last);
          a_cidx  <= ci;
          a_pidx  <= pi;
          if (ci == k_last) begin
            ci <= '0;
            if (pi == last_pt) begin
              drain <= '0;
              state <= S_ASSIGN_DRAIN;
            end else begin
              pi <= pi + 1'b1;
            end
          end else begin
            ci <= ci + 1'b1;
          end
        end
        S_ASSIGN_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == DRAIN_W'(DRAIN_CYCLES - 1)) begin
            ci    <= '0;
            state <= S_UPD_RD;
          end
        end
        S_UPD_RD: begin
          state <= S_UPD_LD;
        end
        S_UPD_LD: begin
          upd_sum <= sum_rd;
          old_x   <= ctr_rd.x;
          old_y   <= ctr_rd.y;
          state   <= S_UPD_DIV;
        end
        // empty cluster keeps its centre
        S_UPD_DIV: begin
          if (upd_sum.cnt == '0) begin
            new_x    <= old_x;
            new_y    <= old_y;
            mv_valid <= 1'b1;
            state    <= S_UPD_MOVE;
          end else if (div_done_x) begin
            new_x    <= COORD_W'(upd_sum.sx[SUM_W-1] ? qn_x : div_q_x);
            new_y    <= COORD_W'(upd_sum.sy[SUM_W-1] ? qn_y : div_q_y);
            mv_valid <= 1'b1;
            state    <= S_UPD_MOVE;
          end
        end
        // movement check and centre write back
        S_UPD_MOVE: begin
          if (d_valid) begin
            if (d_dist > DIST_W'(tol2)) begin
              conv <= 1'b0;
            end
            if (ci == k_last) begin
              pi    <= '0;
              drain <= '0;
              state <= (point_total == '0) ? S_INERT_DRAIN : S_INERT;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_UPD_RD;
            end
          end
        end
        S_INERT: begin
          r0_valid <= 1'b1;
          r0_pidx  <= pi;
          if (pi == last_pt) begin
            drain <= '0;
            state <= S_INERT_DRAIN;
          end else begin
            pi <= pi + 1'b1;
          end
        end
        // end of pass
        S_INERT_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == DRAIN_W'(DRAIN_CYCLES - 1)) begin
            iter <= iter_inc;
            ci   <= '0;
            if (conv || (iter_inc == iter_lim)) begin
              state <= S_EMIT_RD;
            end else begin
              conv        <= 1'b1;
              inertia_acc <= '0;
              state       <= S_CLEAR;
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          center_index <= ci;
          center_x     <= ctr_rd.x;
          center_y     <= ctr_rd.y;
          member_count <= sum_rd.cnt;
          passes_run   <= iter;
          converged    <= conv;
          inertia      <= inertia_acc;
          last_center  <= (ci == k_last);
          out_valid    <= 1'b1;
          state        <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_center) begin
              state <= S_IDLE;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `KMC_ASSERT_IMPLIES(a_ready_no_result, clk, rst, in_ready, !out_valid)
  `KMC_ASSERT(a_div_lockstep, clk, rst, div_done_x == div_done_y)
  `KMC_ASSERT_NEXT(a_last_to_idle, clk, rst, out_valid && out_ready && last_center, in_ready)
  `KMC_ASSERT_IMPLIES(a_acc_in_assign, clk, rst, acc_valid, state == S_ASSIGN || state == S_ASSIGN_DRAIN)

endmodule
